// ===== rtl/geo_bounds_dateline_split_macros.svh =====
// assertion macros for the bounding box block
// included by modules that carry concurrent assertions; no other dependencies
`ifndef GEO_BOUNDS_DATELINE_SPLIT_MACROS_SVH
`define GEO_BOUNDS_DATELINE_SPLIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define GBDS_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the following cycle
`define GBDS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/gbds_pkg.sv =====
// shared types and constants for the bounding box / dateline split block
// no dependencies; used by the controller, the datapath and the top level
package gbds_pkg;

  // field widths
  localparam int ACT_W     = 2;
  localparam int XW        = 25;
  localparam int YW        = 24;
  localparam int SPLIT_W   = 26;
  localparam int OXW       = 27;
  localparam int OYW       = 24;
  localparam int RECT_W    = 1 + 2 * OXW + 2 * OYW;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 208;

  // default fraction bits of the fixed point coordinates
  localparam int COORD_FRAC_BITS_DEF = 16;

  // action codes
  typedef enum logic [ACT_W-1:0] {
    ACT_ADD    = 2'd0,
    ACT_REPORT = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_EXEC
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic prep;
    logic exec;
  } gbds_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             out_busy;
  } gbds_stat_t;

endpackage

// ===== rtl/geo_bounds_dateline_split.sv =====
// top level of the bounding box with dateline split
// depends on gbds_pkg, gbds_ctrl, gbds_datapath and the assertion macro header
//
//  channel  | direction | tdata / tuser contents
//  ---------+-----------+---------------------------------------------------
//  s_*      | in        | tuser: action; tdata: x_coord, y_coord, flags
//  m_*      | out       | tdata: rect1 then rect2 (empty, xmin, xmax, ymin, ymax)
//  cfg_*    | in        | split_lon write, no read-back
//
// each transaction passes through three steps: accept, prepare (unwrap, containment,
// window edge), execute (box update or rectangle build); the next transaction
// is taken in the cycle after execute.
// a report holds in execute while an earlier result waits in the output register.
// reset (rst, synchronous) empties the box and sets split_lon to -180 deg.
`include "geo_bounds_dateline_split_macros.svh"
module geo_bounds_dateline_split import gbds_pkg::*; #(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // x_coord[24:0], y_coord[48:25], over_north[49], over_south[50], zero pad
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // action[1:0]
  input  logic [ACT_W-1:0]       s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // rect1_empty, rect1_xmin, rect1_xmax, rect1_ymin, rect1_ymax,
  // rect2_empty, rect2_xmin, rect2_xmax, rect2_ymin, rect2_ymax, zero pad
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   cfg_we,
  input  logic [SPLIT_W-1:0]     cfg_wdata
);

  gbds_cmd_t  cmd;
  gbds_stat_t stat;

  gbds_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gbds_datapath #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // an accepted transaction keeps the input closed while it is processed
  `GBDS_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready, "input open during processing")
  // an empty rectangle carries all-zero coordinates
  `GBDS_ASSERT_SAME(a_rect1_empty_zero, clk, rst, m_tvalid && m_tdata[0], m_tdata[RECT_W-1:1] == '0, "rect1 empty with coordinates")
  `GBDS_ASSERT_SAME(a_rect2_empty_zero, clk, rst, m_tvalid && m_tdata[RECT_W], m_tdata[2*RECT_W-1:RECT_W+1] == '0, "rect2 empty with coordinates")
  // a new result appears only out of the execute step
  `GBDS_ASSERT_SAME(a_result_from_exec, clk, rst, $rose(m_tvalid), $past(!s_tready), "result without execute")

endmodule

// ===== rtl/gbds_ctrl.sv =====
// controller state machine: accept, prepare, execute
// depends on gbds_pkg
module gbds_ctrl import gbds_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  gbds_stat_t stat,
  output gbds_cmd_t  cmd
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        // a report waits for the output register to free up
        if (!(stat.act == ACT_REPORT && stat.out_busy)) begin
          cmd.exec   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/gbds_datapath.sv =====
// datapath: item registers, bounding box, split window and result register
// depends on gbds_pkg; driven by gbds_ctrl commands
module gbds_datapath import gbds_pkg::*; #(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  gbds_cmd_t              cmd,
  output gbds_stat_t             stat,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic [ACT_W-1:0]       s_tuser,
  input  logic                   cfg_we,
  input  logic [SPLIT_W-1:0]     cfg_wdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  // internal width: holds split_lon + 360 deg and a box shifted by 360 deg
  localparam int AccW = ((COORD_FRAC_BITS + 10 > OXW) ? COORD_FRAC_BITS + 10 : OXW) + 2;

  localparam logic signed [AccW-1:0] DEG90   = AccW'(64'sd90 <<< COORD_FRAC_BITS);
  localparam logic signed [AccW-1:0] DEG180  = AccW'(64'sd180 <<< COORD_FRAC_BITS);
  localparam logic signed [AccW-1:0] DEG360  = AccW'(64'sd360 <<< COORD_FRAC_BITS);
  localparam logic signed [AccW-1:0] NDEG90  = AccW'(-(64'sd90 <<< COORD_FRAC_BITS));
  localparam logic signed [AccW-1:0] NDEG180 = AccW'(-(64'sd180 <<< COORD_FRAC_BITS));
  localparam logic signed [AccW-1:0] NDEG360 = AccW'(-(64'sd360 <<< COORD_FRAC_BITS));
  localparam logic signed [SPLIT_W-1:0] SPLIT_RST =
    SPLIT_W'(-(64'sd180 <<< COORD_FRAC_BITS));

  typedef struct packed {
    logic                   empty;
    logic signed [AccW-1:0] xmin;
    logic signed [AccW-1:0] xmax;
    logic signed [AccW-1:0] ymin;
    logic signed [AccW-1:0] ymax;
  } rect_t;

  // clip to the longitude window and to the latitude range
  function automatic rect_t clip_rect(input rect_t r, input logic signed [AccW-1:0] lo,
                                      input logic signed [AccW-1:0] hi);
    rect_t c;
    c = r;
    if ($signed(r.xmin) < lo) c.xmin = lo;
    if ($signed(r.xmax) > hi) c.xmax = hi;
    if ($signed(r.ymin) < NDEG90) c.ymin = NDEG90;
    if ($signed(r.ymax) > DEG90) c.ymax = DEG90;
    if ($signed(c.xmin) > $signed(c.xmax) || $signed(c.ymin) > $signed(c.ymax)) begin
      c.empty = 1'b1;
    end
    return c;
  endfunction

  // output fields of one rectangle, lowest bit first: empty, xmin, xmax, ymin, ymax
  function automatic logic [RECT_W-1:0] pack_rect(input rect_t r);
    logic [RECT_W-1:0] p;
    if (r.empty) begin
      p = {{(RECT_W-1){1'b0}}, 1'b1};
    end else begin
      p = {r.ymax[OYW-1:0], r.ymin[OYW-1:0], r.xmax[OXW-1:0], r.xmin[OXW-1:0], 1'b0};
    end
    return p;
  endfunction

  // item registers
  logic [ACT_W-1:0]     act;
  logic signed [XW-1:0] x_in;
  logic signed [YW-1:0] y_in;
  logic                 north;
  logic                 south;

  // configuration and box state
  logic signed [SPLIT_W-1:0] split_lon;
  logic                      box_empty;
  logic signed [AccW-1:0]    box_xmin, box_xmax;
  logic signed [YW-1:0]      box_ymin, box_ymax;

  // prepare stage registers
  logic signed [AccW-1:0] x_adj;
  logic                   in_box;
  logic signed [AccW-1:0] win_hi;
  logic                   lo_cut;
  logic signed [AccW-1:0] sh_xmin, sh_xmax;

  logic signed [AccW-1:0] x_ext, split_ext, x_adj_next, shift_c;
  logic                   in_box_next, lo_cut_next;
  rect_t                  box_rect, r1, r2;

  assign x_ext     = {{(AccW-XW){x_in[XW-1]}}, x_in};
  assign split_ext = {{(AccW-SPLIT_W){split_lon[SPLIT_W-1]}}, split_lon};

  assign stat.act      = act;
  assign stat.out_busy = m_tvalid && !m_tready;

  // latch the accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act   <= s_tuser;
      x_in  <= s_tdata[XW-1:0];
      y_in  <= s_tdata[XW+YW-1:XW];
      north <= s_tdata[XW+YW];
      south <= s_tdata[XW+YW+1];
    end
  end

  // point unwrap, containment and window edge
  always_comb begin
    in_box_next = x_ext >= box_xmin && x_ext <= box_xmax &&
                  y_in >= box_ymin && y_in <= box_ymax;
    if (box_xmax > DEG90 && x_ext < NDEG90) begin
      x_adj_next = x_ext + DEG360;
    end else if (box_xmin < NDEG90 && x_ext > DEG90) begin
      x_adj_next = x_ext + NDEG360;
    end else begin
      x_adj_next = x_ext;
    end
    lo_cut_next = box_xmin < split_ext;
    shift_c     = lo_cut_next ? DEG360 : NDEG360;
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      x_adj   <= x_adj_next;
      in_box  <= in_box_next;
      win_hi  <= split_ext + DEG360;
      lo_cut  <= lo_cut_next;
      sh_xmin <= box_xmin + shift_c;
      sh_xmax <= box_xmax + shift_c;
    end
  end

  // report rectangles
  always_comb begin
    rect_t sh_rect;
    box_rect.empty = 1'b0;
    box_rect.xmin  = box_xmin;
    box_rect.xmax  = box_xmax;
    box_rect.ymin  = {{(AccW-YW){box_ymin[YW-1]}}, box_ymin};
    box_rect.ymax  = {{(AccW-YW){box_ymax[YW-1]}}, box_ymax};
    sh_rect        = box_rect;
    sh_rect.xmin   = sh_xmin;
    sh_rect.xmax   = sh_xmax;
    r1             = '0;
    r1.empty       = 1'b1;
    r2             = r1;
    if (!box_empty) begin
      if (north || south) begin
        r1.empty = 1'b0;
        r1.xmin  = NDEG180;
        r1.xmax  = DEG180;
        r1.ymin  = south ? NDEG90 : box_rect.ymin;
        r1.ymax  = north ? DEG90 : box_rect.ymax;
      end else if (lo_cut || box_xmax > win_hi) begin
        r1 = clip_rect(box_rect, split_ext, win_hi);
        r2 = clip_rect(sh_rect, split_ext, win_hi);
      end else begin
        r1 = box_rect;
      end
    end
  end

  // split register
  always_ff @(posedge clk) begin
    if (rst) begin
      split_lon <= SPLIT_RST;
    end else if (cfg_we) begin
      split_lon <= cfg_wdata;
    end
  end

  // box update
  always_ff @(posedge clk) begin
    if (rst) begin
      box_empty <= 1'b1;
      box_xmin  <= '0;
      box_xmax  <= '0;
      box_ymin  <= '0;
      box_ymax  <= '0;
    end else if (cmd.exec) begin
      if (act == ACT_CLEAR) begin
        box_empty <= 1'b1;
        box_xmin  <= '0;
        box_xmax  <= '0;
        box_ymin  <= '0;
        box_ymax  <= '0;
      end else if (act == ACT_ADD) begin
        if (box_empty) begin
          box_empty <= 1'b0;
          box_xmin  <= x_ext;
          box_xmax  <= x_ext;
          box_ymin  <= y_in;
          box_ymax  <= y_in;
        end else if (!in_box) begin
          if (x_adj < box_xmin) box_xmin <= x_adj;
          if (x_adj > box_xmax) box_xmax <= x_adj;
          if (y_in < box_ymin) box_ymin <= y_in;
          if (y_in > box_ymax) box_ymax <= y_in;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.exec && act == ACT_REPORT) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && act == ACT_REPORT) begin
      m_tdata <= {{(OUT_TDATA_W-2*RECT_W){1'b0}}, pack_rect(r2), pack_rect(r1)};
    end
  end

endmodule
